[hw/rtl/alm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, operation codes and helpers for the sorted alarm table.
package alm_pkg;

    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int KIND_W = 3;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;

    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;

    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHECK = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic              enable;
    } t_alarm;

    localparam int ENTRY_W = $bits(t_alarm);

    // hour:minute:second packed together orders like seconds of day
    typedef logic [HOUR_W+MIN_W+SEC_W-1:0] t_key;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    function automatic t_key key_of(input t_alarm a);
        return {a.hour, a.minute, a.second};
    endfunction

    function automatic logic time_ok(input logic [HOUR_W-1:0] h,
                                     input logic [MIN_W-1:0] m,
                                     input logic [SEC_W-1:0] s);
        return (h <= HOUR_MAX) && (m <= MIN_MAX) && (s <= SEC_MAX);
    endfunction

endpackage

[hw/rtl/alm_req_if.sv]
`timescale 1ns / 1ps
// Request channel: one table operation per word.
interface alm_req_if;
    logic                       valid;
    logic                       ready;
    logic [alm_pkg::KIND_W-1:0] kind;
    logic [alm_pkg::HOUR_W-1:0] hour;
    logic [alm_pkg::MIN_W-1:0]  minute;
    logic [alm_pkg::SEC_W-1:0]  second;
    logic [alm_pkg::IDX_W-1:0]  index;
    logic                       enable_value;

    modport source (
        output valid, kind, hour, minute, second, index, enable_value,
        input  ready
    );
    modport sink (
        input  valid, kind, hour, minute, second, index, enable_value,
        output ready
    );
endinterface

[hw/rtl/alm_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: one result word per operation.
interface alm_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       success;
    logic [alm_pkg::HOUR_W-1:0] alarm_hour;
    logic [alm_pkg::MIN_W-1:0]  alarm_minute;
    logic [alm_pkg::SEC_W-1:0]  alarm_second;
    logic                       alarm_enabled;
    logic [alm_pkg::CNT_W-1:0]  entry_count;

    modport source (
        output valid, success, alarm_hour, alarm_minute, alarm_second,
               alarm_enabled, entry_count,
        input  ready
    );
    modport sink (
        input  valid, success, alarm_hour, alarm_minute, alarm_second,
               alarm_enabled, entry_count,
        output ready
    );
endinterface

[hw/rtl/alm_cmp.sv]
`timescale 1ns / 1ps
// Shared time comparator used by the scan over the table.
module alm_cmp (
    input  alm_pkg::t_key i_a,
    input  alm_pkg::t_key i_b,
    output alm_pkg::t_cmp o_res
);
    import alm_pkg::*;

    assign o_res.lt = (i_a < i_b);
    assign o_res.eq = (i_a == i_b);
endmodule

[hw/rtl/alm_store.sv]
`timescale 1ns / 1ps
// Entry memory: one write port, one registered read port.
module alm_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  alm_pkg::t_alarm        i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output alm_pkg::t_alarm        o_rdata
);
    import alm_pkg::*;

    t_alarm r_mem [DEPTH];
    t_alarm r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/sorted_time_alarm_table.sv]
`timescale 1ns / 1ps
// Sorted alarm table: sequencer, entry memory and shared comparator.
//
// Holds up to MAX_ENTRIES alarm times in ascending time order in a memory with
// one write and one read port and serves one operation at a time; the request
// side is not ready until the result word has been loaded into the output
// register, which then waits for the sink while the next request is taken.
// Every entry visit goes through the one memory read port, one entry per cycle.
// Read and set-enable visit only the indexed entry; check scans every valid
// entry; delete at index k moves each entry above k down one slot; add scans
// for a duplicate, then moves the entries from its sorted position p up one
// slot and writes the new entry at p. An add on a full table, a time out of
// range, an invalid index or an unknown kind goes straight to the result.
// Every result waits while the output register is still occupied.
// The table needs no clearing pass after reset: only entries below the count
// are ever used.
module sorted_time_alarm_table #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alm_req_if.sink   i_req,
    alm_rsp_if.source o_rsp
);
    import alm_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_RMW   = 3'd4;
    localparam logic [2:0] S_RDAT  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_qv, n_qv;
    logic              r_ovalid, n_ovalid;

    logic [KIND_W-1:0] r_kind, n_kind;
    t_key              r_key, n_key;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_en, n_en;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_pos, n_pos;
    logic              r_dup, n_dup;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_src, n_src;
    logic [AW-1:0]     r_wa, n_wa;
    logic              r_up, n_up;
    logic              r_ok, n_ok;
    t_alarm            r_rd, n_rd;
    logic              r_o_ok, n_o_ok;
    t_alarm            r_o_rd, n_o_rd;
    logic [CNT_W-1:0]  r_o_cnt, n_o_cnt;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_alarm            mem_wdata;
    logic [AW-1:0]     mem_raddr;
    t_alarm            mem_q;
    t_cmp              cmp_res;

    t_key              in_key;
    logic              in_time_ok;
    logic              in_idx_ok;

    alm_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    alm_cmp u_cmp (
        .i_a   (key_of(mem_q)),
        .i_b   (r_key),
        .o_res (cmp_res)
    );

    assign in_key     = {i_req.hour, i_req.minute, i_req.second};
    assign in_time_ok = time_ok(i_req.hour, i_req.minute, i_req.second);
    assign in_idx_ok  = XW'(i_req.index) < XW'(r_count);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_qv     = r_qv;
        n_ovalid = r_ovalid;
        n_kind   = r_kind;
        n_key    = r_key;
        n_idx    = r_idx;
        n_en     = r_en;
        n_ptr    = r_ptr;
        n_pos    = r_pos;
        n_dup    = r_dup;
        n_cnt    = r_cnt;
        n_src    = r_src;
        n_wa     = r_wa;
        n_up     = r_up;
        n_ok     = r_ok;
        n_rd     = r_rd;
        n_o_ok   = r_o_ok;
        n_o_rd   = r_o_rd;
        n_o_cnt  = r_o_cnt;

        mem_we    = 1'b0;
        mem_waddr = r_wa;
        mem_wdata = mem_q;
        mem_raddr = r_ptr[AW-1:0];

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                mem_raddr = AW'(i_req.index);
                if (i_req.valid) begin
                    n_kind  = i_req.kind;
                    n_key   = in_key;
                    n_idx   = AW'(i_req.index);
                    n_en    = i_req.enable_value;
                    n_ptr   = '0;
                    n_pos   = '0;
                    n_dup   = 1'b0;
                    n_qv    = 1'b0;
                    n_ok    = 1'b0;
                    n_rd    = '0;
                    n_state = S_RESP;
                    unique case (i_req.kind)
                        KIND_ADD: begin
                            if ((r_count < CW'(MAX_ENTRIES)) && in_time_ok) begin
                                n_state = S_SCAN;
                            end
                        end
                        KIND_CHECK: begin
                            if (in_time_ok) begin
                                n_state = S_SCAN;
                            end
                        end
                        KIND_SET: begin
                            if (in_idx_ok) begin
                                n_state = S_RMW;
                            end
                        end
                        KIND_DEL: begin
                            if (in_idx_ok) begin
                                n_cnt   = CW'(XW'(r_count) - XW'(i_req.index) - XW'(1));
                                n_src   = CW'(XW'(i_req.index) + XW'(1));
                                n_up    = 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        KIND_READ: begin
                            if (in_idx_ok) begin
                                n_state = S_RDAT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                mem_raddr = r_ptr[AW-1:0];
                if (r_qv) begin
                    if (cmp_res.lt) begin
                        n_pos = r_pos + CW'(1);
                    end
                    if (cmp_res.eq) begin
                        n_dup = 1'b1;
                    end
                end
                if (r_ptr < r_count) begin
                    n_ptr = r_ptr + CW'(1);
                    n_qv  = 1'b1;
                end else begin
                    n_qv = 1'b0;
                    if (!r_qv) begin
                        if (r_kind == KIND_CHECK) begin
                            n_ok    = !r_dup;
                            n_state = S_RESP;
                        end else if (r_dup) begin
                            n_state = S_RESP;
                        end else begin
                            n_cnt   = r_count - r_pos;
                            n_src   = r_count - CW'(1);
                            n_up    = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                mem_raddr = r_src[AW-1:0];
                if (r_qv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wa;
                    mem_wdata = mem_q;
                end
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - CW'(1);
                    n_qv  = 1'b1;
                    if (r_up) begin
                        n_src = r_src + CW'(1);
                        n_wa  = AW'(r_src - CW'(1));
                    end else begin
                        n_src = r_src - CW'(1);
                        n_wa  = AW'(r_src + CW'(1));
                    end
                end else begin
                    n_qv = 1'b0;
                    if (!r_qv) begin
                        if (r_up) begin
                            n_count = r_count - CW'(1);
                            n_ok    = 1'b1;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                end
            end
            S_PUT: begin
                mem_we           = 1'b1;
                mem_waddr        = r_pos[AW-1:0];
                mem_wdata.hour   = r_key[HOUR_W+MIN_W+SEC_W-1:MIN_W+SEC_W];
                mem_wdata.minute = r_key[MIN_W+SEC_W-1:SEC_W];
                mem_wdata.second = r_key[SEC_W-1:0];
                mem_wdata.enable = 1'b0;
                n_count          = r_count + CW'(1);
                n_ok             = 1'b1;
                n_state          = S_RESP;
            end
            S_RMW: begin
                mem_we           = 1'b1;
                mem_waddr        = r_idx;
                mem_wdata        = mem_q;
                mem_wdata.enable = r_en;
                n_state          = S_RESP;
            end
            S_RDAT: begin
                n_rd    = mem_q;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_o_ok   = r_ok;
                    n_o_rd   = r_rd;
                    n_o_cnt  = CNT_W'(r_count);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_qv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_qv     <= n_qv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_en    <= n_en;
        r_ptr   <= n_ptr;
        r_pos   <= n_pos;
        r_dup   <= n_dup;
        r_cnt   <= n_cnt;
        r_src   <= n_src;
        r_wa    <= n_wa;
        r_up    <= n_up;
        r_ok    <= n_ok;
        r_rd    <= n_rd;
        r_o_ok  <= n_o_ok;
        r_o_rd  <= n_o_rd;
        r_o_cnt <= n_o_cnt;
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.success       = r_o_ok;
    assign o_rsp.alarm_hour    = r_o_rd.hour;
    assign o_rsp.alarm_minute  = r_o_rd.minute;
    assign o_rsp.alarm_second  = r_o_rd.second;
    assign o_rsp.alarm_enabled = r_o_rd.enable;
    assign o_rsp.entry_count   = r_o_cnt;
endmodule

[hw/rtl/alm_chk.sv]
`timescale 1ns / 1ps
// Port-level checks for the sorted alarm table, bound to the top level.
module alm_chk #(
    parameter int MAX_ENTRIES = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic [alm_pkg::CNT_W-1:0] i_entry_count
);
    import alm_pkg::*;

    a_reset_clears_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result word pending after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous operation in flight");

    a_rsp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result word dropped before it was taken");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((MAX_ENTRIES > 31) || (i_entry_count <= CNT_W'(MAX_ENTRIES))))
        else $error("entry count above table size");
endmodule

bind sorted_time_alarm_table alm_chk #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_alm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_entry_count (o_rsp.entry_count)
);

[sim/sorted_time_alarm_table_test.sv]
`timescale 1ns / 1ps
// Self-checking test of the sorted alarm table against a tracking table.
package alarm_table_test_pkg;
    import alm_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN = 60;
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [IDX_W-1:0]  index;
        logic              enable_value;
    } t_op;

    typedef struct packed {
        logic              success;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic              enabled;
        logic [CNT_W-1:0]  entry_count;
    } t_reply;

    class alarm_table_tracker;
        t_alarm slots[TABLE_DEPTH];
        int     used;
        t_reply expected_replies[$];
        int     errors;
        int     words;
        int     replies;
        int     adds_stored;
        int     full_refusals;
        int     dup_refusals;
        int     deletes_done;
        int     peak;

        function new();
            foreach (slots[i]) slots[i] = '0;
            used = 0;
            errors = 0;
            words = 0;
            replies = 0;
            adds_stored = 0;
            full_refusals = 0;
            dup_refusals = 0;
            deletes_done = 0;
            peak = 0;
        endfunction

        function int day_sec(int h, int m, int s);
            return h * SEC_PER_HOUR + m * SEC_PER_MIN + s;
        endfunction

        function void report(string msg);
            if (errors < 100) $display("MISMATCH %s", msg);
            errors++;
        endfunction

        function void note_request(t_op op);
            t_reply r;
            int     t;
            int     pos;
            int     i;
            bit     in_range;
            bit     taken;
            r = '0;
            in_range = (op.hour <= HOUR_MAX) && (op.minute <= MIN_MAX)
                && (op.second <= SEC_MAX);
            t = day_sec(op.hour, op.minute, op.second);
            pos = 0;
            while (pos < used
                && day_sec(slots[pos].hour, slots[pos].minute, slots[pos].second) < t)
                pos++;
            taken = 1'b0;
            if (pos < used)
                taken = day_sec(slots[pos].hour, slots[pos].minute,
                    slots[pos].second) == t;
            words++;
            case (op.kind)
                KIND_ADD: begin
                    if (used >= TABLE_DEPTH) begin
                        full_refusals++;
                    end else if (in_range && taken) begin
                        dup_refusals++;
                    end else if (in_range) begin
                        for (i = used; i > pos; i--) slots[i] = slots[i-1];
                        slots[pos].hour = op.hour;
                        slots[pos].minute = op.minute;
                        slots[pos].second = op.second;
                        slots[pos].enable = 1'b0;
                        used++;
                        adds_stored++;
                        r.success = 1'b1;
                    end
                end
                KIND_CHECK: begin
                    r.success = in_range && !taken;
                end
                KIND_SET: begin
                    if (op.index < used) slots[op.index].enable = op.enable_value;
                end
                KIND_DEL: begin
                    if (op.index < used) begin
                        for (i = int'(op.index); i + 1 < used; i++) slots[i] = slots[i+1];
                        used--;
                        slots[used] = '0;
                        deletes_done++;
                        r.success = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (op.index < used) begin
                        r.hour = slots[op.index].hour;
                        r.minute = slots[op.index].minute;
                        r.second = slots[op.index].second;
                        r.enabled = slots[op.index].enable;
                    end
                end
                default: begin
                end
            endcase
            if (used > peak) peak = used;
            r.entry_count = used[CNT_W-1:0];
            expected_replies.push_back(r);
        endfunction

        function void compare(string field, int got, int want);
            if (got != want)
                report($sformatf("reply %0d %s: got %0d, expected %0d",
                    replies, field, got, want));
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (expected_replies.size() == 0) begin
                report($sformatf("reply %0d arrived with no request waiting",
                    replies));
            end else begin
                want = expected_replies.pop_front();
                compare("success", got.success, want.success);
                compare("alarm_hour", got.hour, want.hour);
                compare("alarm_minute", got.minute, want.minute);
                compare("alarm_second", got.second, want.second);
                compare("alarm_enabled", got.enabled, want.enabled);
                compare("entry_count", got.entry_count, want.entry_count);
            end
            replies++;
        endfunction
    endclass
endpackage

module sorted_time_alarm_table_test;
    import alm_pkg::*;
    import alarm_table_test_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic hold_request = 1'b0;
    int   cycle_count = 0;
    int   src_idle_pct = 0;
    int   sink_idle_pct = 0;
    int   holds_done = 0;

    alarm_table_tracker tracker = new();

    alm_req_if req_bus();
    alm_rsp_if rsp_bus();

    sorted_time_alarm_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_req(req_bus),
        .o_rsp(rsp_bus)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                cycle_count, tracker.expected_replies.size());
            $display("sorted_time_alarm_table_test NOT OK");
            $finish;
        end
    end

    // Reply side: check each accepted word, hold off on request
    initial begin
        int     hold_left;
        t_reply got;
        hold_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
                got.success = rsp_bus.success;
                got.hour = rsp_bus.alarm_hour;
                got.minute = rsp_bus.alarm_minute;
                got.second = rsp_bus.alarm_second;
                got.enabled = rsp_bus.alarm_enabled;
                got.entry_count = rsp_bus.entry_count;
                tracker.check_reply(got);
            end
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request <= 1'b0;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [KIND_W-1:0] kind,
                             input logic [HOUR_W-1:0] hour,
                             input logic [MIN_W-1:0] minute,
                             input logic [SEC_W-1:0] second,
                             input logic [IDX_W-1:0] index,
                             input logic enable_value);
        t_op op;
        int  gap;
        op.kind = kind;
        op.hour = hour;
        op.minute = minute;
        op.second = second;
        op.index = index;
        op.enable_value = enable_value;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.kind <= kind;
        req_bus.hour <= hour;
        req_bus.minute <= minute;
        req_bus.second <= second;
        req_bus.index <= index;
        req_bus.enable_value <= enable_value;
        do @(posedge clk); while (!req_bus.ready);
        tracker.note_request(op);
    endtask

    // Alternate fill and drain stretches so the table keeps reaching full and empty
    task automatic run_random(input int src_pct, input int sink_pct, input int n_words,
                              input int hold_at);
        int                n;
        int                r;
        int                p;
        bit                filling;
        logic [KIND_W-1:0] kind;
        logic [HOUR_W-1:0] h;
        logic [MIN_W-1:0]  m;
        logic [SEC_W-1:0]  s;
        logic [IDX_W-1:0]  idx;
        logic              en;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        for (n = 0; n < n_words; n++) begin
            filling = ((n / 64) % 2) == 0;
            if (n == hold_at) hold_request <= 1'b1;
            r = $urandom_range(99);
            if (r < (filling ? 45 : 15)) kind = KIND_ADD;
            else if (r < (filling ? 57 : 27)) kind = KIND_CHECK;
            else if (r < (filling ? 69 : 39)) kind = KIND_SET;
            else if (r < (filling ? 77 : 70)) kind = KIND_DEL;
            else if (r < 95) kind = KIND_READ;
            else kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
            r = $urandom_range(99);
            if (r < 25 && tracker.used > 0) begin
                p = $urandom_range(tracker.used - 1);
                h = tracker.slots[p].hour;
                m = tracker.slots[p].minute;
                s = tracker.slots[p].second;
            end else if (r < 88) begin
                h = HOUR_W'($urandom_range(HOUR_MAX));
                m = MIN_W'($urandom_range(MIN_MAX));
                s = SEC_W'($urandom_range(SEC_MAX));
            end else begin
                h = HOUR_W'($urandom_range((1 << HOUR_W) - 1));
                m = MIN_W'($urandom_range((1 << MIN_W) - 1));
                s = SEC_W'($urandom_range((1 << SEC_W) - 1));
            end
            if (tracker.used > 0 && $urandom_range(99) < 80)
                idx = IDX_W'($urandom_range(tracker.used - 1));
            else
                idx = IDX_W'($urandom_range(TABLE_DEPTH - 1));
            en = 1'($urandom_range(1));
            send_word(kind, h, m, s, idx, en);
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.kind <= KIND_READ;
        req_bus.hour <= '0;
        req_bus.minute <= '0;
        req_bus.second <= '0;
        req_bus.index <= '0;
        req_bus.enable_value <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 14;
        sink_idle_pct = 55;
        send_word(KIND_READ, 5'd0, 6'd0, 6'd0, 4'd0, 1'b0);
        send_word(KIND_SET, 5'd0, 6'd0, 6'd0, 4'd0, 1'b1);
        send_word(KIND_DEL, 5'd0, 6'd0, 6'd0, 4'd0, 1'b0);
        send_word(KIND_CHECK, 5'd0, 6'd0, 6'd0, 4'd0, 1'b0);
        send_word(KIND_CHECK, 5'd24, 6'd0, 6'd0, 4'd0, 1'b0);
        send_word(KIND_CHECK, 5'd31, 6'd63, 6'd63, 4'd15, 1'b1);
        send_word(KIND_CHECK, 5'd23, 6'd60, 6'd0, 4'd0, 1'b0);
        send_word(KIND_CHECK, 5'd0, 6'd0, 6'd60, 4'd0, 1'b0);
        send_word(KIND_ADD, 5'd23, 6'd59, 6'd59, 4'd15, 1'b1);
        send_word(KIND_ADD, 5'd0, 6'd0, 6'd0, 4'd0, 1'b0);
        send_word(KIND_ADD, 5'd12, 6'd30, 6'd30, 4'd7, 1'b1);
        send_word(KIND_ADD, 5'd12, 6'd30, 6'd30, 4'd0, 1'b0);
        send_word(KIND_ADD, 5'd24, 6'd0, 6'd0, 4'd0, 1'b0);
        send_word(KIND_CHECK, 5'd12, 6'd30, 6'd30, 4'd0, 1'b0);
        send_word(KIND_SET, 5'd0, 6'd0, 6'd0, 4'd1, 1'b1);
        send_word(KIND_READ, 5'd0, 6'd0, 6'd0, 4'd1, 1'b0);
        send_word(KIND_READ, 5'd0, 6'd0, 6'd0, 4'd2, 1'b0);
        send_word(KIND_READ, 5'd31, 6'd63, 6'd63, 4'd15, 1'b1);
        send_word(KIND_SET, 5'd0, 6'd0, 6'd0, 4'd15, 1'b1);
        send_word(KIND_SPARE_FIRST, 5'd31, 6'd63, 6'd63, 4'd15, 1'b1);
        send_word(KIND_SPARE_FIRST + 3'd1, 5'd1, 6'd2, 6'd3, 4'd0, 1'b0);
        send_word(KIND_SPARE_LAST, 5'd23, 6'd59, 6'd59, 4'd1, 1'b1);
        send_word(KIND_DEL, 5'd0, 6'd0, 6'd0, 4'd3, 1'b0);
        send_word(KIND_DEL, 5'd0, 6'd0, 6'd0, 4'd1, 1'b0);
        send_word(KIND_READ, 5'd0, 6'd0, 6'd0, 4'd1, 1'b0);

        run_random(14, 55, 575, 200);
        run_random(55, 14, 575, -1);
        run_random(0, 0, 575, 300);
        req_bus.valid <= 1'b0;

        while (tracker.expected_replies.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d operations: %0d adds stored, %0d refused on a full table",
            tracker.words, tracker.adds_stored, tracker.full_refusals);
        $display("%0d duplicates refused, %0d deletes, peak of %0d entries, %0d long %s",
            tracker.dup_refusals, tracker.deletes_done, tracker.peak, holds_done,
            $sformatf("reply hold-offs, %0d mismatches", tracker.errors));
        if (tracker.errors == 0) begin
            $display("sorted_time_alarm_table_test OK");
        end else begin
            $display("sorted_time_alarm_table_test NOT OK");
        end
        $finish;
    end
endmodule
